/* src/eas_pkg.sv */
// Shared types, constants and command structures for the encoder angle and speed filter.
package eas_pkg;

	// Encoder geometry.
	localparam int COUNTS_PER_REV = 4000;
	localparam int SPAN_REVS      = 16;
	localparam int SPAN_COUNTS    = COUNTS_PER_REV * SPAN_REVS;

	// Speed scaling: position difference times rate, then times 16 * 60 in Q14.
	localparam int SEC_PER_MIN    = 60;
	localparam int SPEED_GAIN     = 16;
	localparam int SPEED_SCALE    = SPEED_GAIN * SEC_PER_MIN;
	localparam int Q_SHIFT        = 14;
	localparam int RATE_SHIFT     = 2;

	// Field widths.
	localparam int CW             = 16;
	localparam int CFG_IW         = 2;
	localparam int WITHIN_W       = $clog2(COUNTS_PER_REV);

	// Reciprocal for the count within one revolution (estimate is low by at most one).
	localparam int      REV_SHIFT = 22;
	localparam longint  REV_MUL   = (64'd1 << REV_SHIFT) / COUNTS_PER_REV;
	localparam int      REV_MW    = $clog2(REV_MUL + 1);
	localparam int      REV_PW    = CW + REV_MW;
	localparam int      REV_QW    = REV_PW - REV_SHIFT;

	// Reciprocal for the position over the whole span, numerator is count * 65536.
	localparam int      POS_SHIFT = 34;
	localparam longint  POS_MUL   = (64'd1 << POS_SHIFT) / SPAN_COUNTS;
	localparam int      POS_MW    = $clog2(POS_MUL + 1);
	localparam int      POS_PW    = CW + POS_MW;
	localparam int      POS_QW    = POS_PW - (POS_SHIFT - CW);

	// Configuration register indexes.
	typedef enum logic [CFG_IW-1:0] {
		CFG_ANGLE_FACTOR = 2'd0,
		CFG_SPEED_RATE   = 2'd1,
		CFG_FILTER_COEF  = 2'd2
	} cfg_reg_t;

	// Input word.
	typedef struct packed {
		logic          mode;
		logic [CW-1:0] enc_ticks;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic        [CW-1:0] electrical_angle;
		logic        [CW-1:0] span_position;
		logic signed [CW-1:0] filtered_speed;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic do_div;
		logic do_fix;
		logic do_angle;
		logic do_rate;
		logic do_scale;
		logic do_f1;
		logic do_f2;
		logic load_out;
	} eas_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mode;
	} eas_status_t;

endpackage

/* src/eas_dpath.sv */
// Datapath: configuration registers, reciprocal division, shared multiplier and IIR filter.
module eas_dpath import eas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CW-1:0]     cfg_data,
	input  in_word_t          item,
	input  eas_cmd_t          cmd,
	output eas_status_t       status,
	output out_word_t         result
);

	// Saturate a wide signed value to 16 bits.
	function automatic logic signed [CW-1:0] clamp_s16(input logic signed [47:0] x);
		logic signed [CW-1:0] r;
		if (x > 48'sd32767) begin
			r = 16'sh7fff;
		end else if (x < -48'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = x[CW-1:0];
		end
		return r;
	endfunction

	logic [CW-1:0]           angle_factor_q;
	logic [CW-1:0]           speed_rate_q;
	logic [CW-1:0]           filter_coef_q;
	logic [CW-1:0]           last_q;
	logic signed [CW-1:0]    fo_q;

	logic                    mode_q;
	logic [CW-1:0]           count_q;
	logic [REV_QW-1:0]       rev_est_q;
	logic [POS_QW-1:0]       pos_est_q;
	logic [WITHIN_W-1:0]     within_q;
	logic [CW-1:0]           pos_q;
	logic [CW-1:0]           angle_q;
	logic signed [33:0]      prod_q;
	logic signed [CW-1:0]    speed_q;
	logic signed [19:0]      acc_q;

	logic [REV_PW-1:0]       rev_prod;
	logic [POS_PW-1:0]       pos_prod;
	logic [16:0]             rev_qc;
	logic [16:0]             rev_rem;
	logic [16:0]             within_fix;
	logic [47:0]             pos_num;
	logic [47:0]             pos_qs;
	logic [47:0]             pos_rem;
	logic [CW-1:0]           pos_fix;
	logic [CW-1:0]           pos_diff;
	logic signed [16:0]      coef_c;
	logic signed [16:0]      mul_a;
	logic signed [16:0]      mul_b;
	logic signed [33:0]      prod;
	logic signed [43:0]      scaled;
	logic signed [21:0]      y_sum;

	// Configuration writes and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_factor_q <= 16'd65;
			speed_rate_q   <= 16'd5000;
			filter_coef_q  <= 16'd998;
			last_q         <= '0;
			fo_q           <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ANGLE_FACTOR: angle_factor_q <= cfg_data;
					CFG_SPEED_RATE:   speed_rate_q   <= cfg_data;
					CFG_FILTER_COEF:  filter_coef_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.do_f2) begin
				fo_q   <= clamp_s16(48'(y_sum >>> 1));
				last_q <= pos_q;
			end
		end
	end

	// Quotient estimates by multiplication with the reciprocal constants.
	assign rev_prod = REV_PW'(count_q) * REV_PW'(REV_MUL);
	assign pos_prod = POS_PW'(count_q) * POS_PW'(POS_MUL);

	// One compare and subtract corrects each estimate.
	always_comb begin
		rev_qc     = 17'(rev_est_q * COUNTS_PER_REV);
		rev_rem    = 17'(count_q) - rev_qc;
		within_fix = (rev_rem >= 17'(COUNTS_PER_REV)) ? rev_rem - 17'(COUNTS_PER_REV)
		                                               : rev_rem;
		pos_num    = {16'b0, count_q, 16'b0};
		pos_qs     = 48'(pos_est_q) * 48'(SPAN_COUNTS);
		pos_rem    = pos_num - pos_qs;
		pos_fix    = (pos_rem >= 48'(SPAN_COUNTS)) ? 16'(pos_est_q + POS_QW'(1))
		                                           : 16'(pos_est_q);
	end

	// Shared signed multiplier, operands chosen by the current step.
	assign pos_diff = pos_q - last_q;
	assign coef_c   = 17'sd32768 - $signed({1'b0, filter_coef_q});

	always_comb begin
		mul_a = $signed({{(17-WITHIN_W){1'b0}}, within_q});
		mul_b = $signed({1'b0, angle_factor_q});
		priority if (cmd.do_rate) begin
			mul_a = 17'($signed(pos_diff));
			mul_b = $signed({1'b0, speed_rate_q});
		end else if (cmd.do_f1) begin
			mul_a = $signed({1'b0, filter_coef_q});
			mul_b = 17'(speed_q);
		end else if (cmd.do_f2) begin
			mul_a = coef_c;
			mul_b = 17'(fo_q);
		end else begin
			mul_a = $signed({{(17-WITHIN_W){1'b0}}, within_q});
			mul_b = $signed({1'b0, angle_factor_q});
		end
	end

	assign prod = mul_a * mul_b;

	// Rpm scaling and filter sum.
	assign scaled = 44'(prod_q >>> RATE_SHIFT) * 44'(SPEED_SCALE);
	assign y_sum  = 22'(acc_q) + 22'(prod >>> Q_SHIFT) + 22'sd1;

	// Working registers of the sequence.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q  <= item.mode;
			count_q <= item.enc_ticks;
		end
		if (cmd.do_div) begin
			rev_est_q <= rev_prod[REV_PW-1:REV_SHIFT];
			pos_est_q <= pos_prod[POS_PW-1:POS_SHIFT-CW];
		end
		if (cmd.do_fix) begin
			within_q <= within_fix[WITHIN_W-1:0];
			pos_q    <= pos_fix;
		end
		if (cmd.do_angle) begin
			angle_q <= prod[CW-1:0];
		end
		if (cmd.do_rate) begin
			prod_q <= prod;
		end
		if (cmd.do_scale) begin
			speed_q <= clamp_s16(48'(scaled >>> Q_SHIFT));
		end
		if (cmd.do_f1) begin
			acc_q <= 20'(prod >>> Q_SHIFT);
		end
		if (cmd.load_out) begin
			result.electrical_angle <= angle_q;
			result.span_position    <= pos_q;
			result.filtered_speed   <= fo_q;
		end
	end

	assign status.mode = mode_q;

endmodule

/* src/eas_ctrl.sv */
// Controller: sequences the datapath steps and runs both handshakes.
module eas_ctrl import eas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	output logic        result_valid,
	input  logic        result_ready,
	input  eas_status_t status,
	output eas_cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DIV   = 9'b000000010,
		ST_FIX   = 9'b000000100,
		ST_ANGLE = 9'b000001000,
		ST_RATE  = 9'b000010000,
		ST_SCALE = 9'b000100000,
		ST_F1    = 9'b001000000,
		ST_F2    = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Step commands decoded from the state.
	always_comb begin
		cmd.load_in  = item_valid && (state_q == ST_IDLE);
		cmd.do_div   = (state_q == ST_DIV);
		cmd.do_fix   = (state_q == ST_FIX);
		cmd.do_angle = (state_q == ST_ANGLE);
		cmd.do_rate  = (state_q == ST_RATE);
		cmd.do_scale = (state_q == ST_SCALE);
		cmd.do_f1    = (state_q == ST_F1);
		cmd.do_f2    = (state_q == ST_F2);
		cmd.load_out = (state_q == ST_DONE) && (!out_valid_q || result_ready);
	end

	// Next state; the speed steps run only when the word asks for them.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (item_valid) state_d = ST_DIV;
			ST_DIV:   state_d = ST_FIX;
			ST_FIX:   state_d = ST_ANGLE;
			ST_ANGLE: state_d = status.mode ? ST_RATE : ST_DONE;
			ST_RATE:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_F1;
			ST_F1:    state_d = ST_F2;
			ST_F2:    state_d = ST_DONE;
			ST_DONE:  if (cmd.load_out) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

endmodule

/* src/encoder_angle_speed_filter.sv */
// Top level of the encoder angle, position and filtered speed block.
// An accepted word runs the division, correction and angle steps, then the rate, scaling and
// filter steps when its mode bit is set. A new word is taken only once the previous one is done;
// the reciprocal division, its correction and the single shared 17x17 multiplier are used in turn.
// A result waiting in the output register does not stop the next word being worked on.
// Asynchronous reset clears the sequencer, the output valid flag, the stored position
// and filter output, and loads the register defaults.
module encoder_angle_speed_filter import eas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  in_word_t          item,
	output logic              result_valid,
	input  logic              result_ready,
	output out_word_t         result,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CW-1:0]     cfg_data
);

	eas_cmd_t    cmd;
	eas_status_t status;

	// Sequencer.
	eas_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Arithmetic and state.
	eas_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// After a word is taken the block is busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("word accepted while the previous one was still in progress");

	// A fresh result only follows a cycle of work, never an idle cycle.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result raised without a word being worked on");

	// Nothing is loaded into the output register while the controller is idle.
	a_no_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !cmd.load_out)
		else $error("output register loaded while idle");

endmodule

/* sim/encoder_angle_speed_filter_tb.sv */
// Self-checking testbench for the encoder angle, position and filtered speed block.
module encoder_angle_speed_filter_tb import eas_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 175;
	localparam int DIR_ROWS    = 25;

	// Register values that the block loads at reset.
	localparam logic [CW-1:0] DEF_ANGLE_FACTOR = 16'd65;
	localparam logic [CW-1:0] DEF_SPEED_RATE   = 16'd5000;
	localparam logic [CW-1:0] DEF_FILTER_COEF  = 16'd998;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	// One line of the directed table: either a word to send or a register write.
	typedef struct {
		row_kind_t     kind;
		cfg_reg_t      reg_idx;
		logic [CW-1:0] value;
		logic          mode;
		logic          typed;
		out_word_t     want;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_word_t  item;
	logic      result_valid;
	logic      result_ready;
	out_word_t result;
	logic      cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CW-1:0]     cfg_data;

	// Typed-in expectation that travels alongside the word being offered.
	logic      item_typed;
	out_word_t item_want;

	// Shadow copy of the registers and of the block's state.
	logic [CW-1:0]        fac_sh;
	logic [CW-1:0]        rate_sh;
	logic [CW-1:0]        coef_sh;
	logic [CW-1:0]        last_pos_sh;
	logic signed [CW-1:0] filt_sh;

	out_word_t due_results[$];
	int        words_sent;
	int        results_seen;
	int        fail_cnt;
	int        cycle_cnt;
	logic      send_burst;
	logic      take_burst;

	stim_row_t dir_tab [DIR_ROWS];

	encoder_angle_speed_filter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Saturate a wide value to the int16 range.
	function automatic longint sat16(longint x);
		if (x > 32767)
			return 32767;
		if (x < -32768)
			return -32768;
		return x;
	endfunction

	// Work out angle, position and filtered speed for one word, advancing the shadow state in mode 1.
	function automatic out_word_t track_encoder(in_word_t w);
		logic [31:0]        prod;
		logic [31:0]        posq;
		logic [CW-1:0]      rev_cnt;
		logic [CW-1:0]      pdiff;
		logic signed [CW-1:0] diff;
		longint             spd;
		longint             coef;
		longint             y;
		out_word_t          r;
		rev_cnt = w.enc_ticks % 16'(COUNTS_PER_REV);
		prod = {16'h0, rev_cnt} * {16'h0, fac_sh};
		r.electrical_angle = prod[CW-1:0];
		posq = {w.enc_ticks, 16'h0} / 32'(SPAN_COUNTS);
		r.span_position = posq[CW-1:0];
		if (w.mode) begin
			pdiff = posq[CW-1:0] - last_pos_sh;
			diff = signed'(pdiff);
			spd = longint'(diff) * longint'({48'h0, rate_sh});
			spd = spd >>> RATE_SHIFT;
			spd = (spd * longint'(SPEED_SCALE)) >>> Q_SHIFT;
			spd = sat16(spd);
			coef = longint'({48'h0, coef_sh});
			y = ((coef * spd) >>> Q_SHIFT)
				+ (((64'sd32768 - coef) * longint'(filt_sh)) >>> Q_SHIFT) + 1;
			filt_sh = CW'(sat16(y >>> 1));
			last_pos_sh = posq[CW-1:0];
		end
		r.filtered_speed = filt_sh;
		return r;
	endfunction

	task automatic check_field(string fname, logic [CW-1:0] want, logic [CW-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d (0x%h) got %0d (0x%h)",
				$time, fname, want, want, got, got);
			fail_cnt++;
		end
	endtask

	// Run watchdog.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("encoder_angle_speed_filter_tb NOT OK");
			$finish;
		end
	end

	// Monitor: track register writes, predict accepted words and check accepted results.
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t predicted;
		if (!arst_n) begin
			fac_sh = DEF_ANGLE_FACTOR;
			rate_sh = DEF_SPEED_RATE;
			coef_sh = DEF_FILTER_COEF;
			last_pos_sh = '0;
			filt_sh = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ANGLE_FACTOR: fac_sh = cfg_data;
					CFG_SPEED_RATE:   rate_sh = cfg_data;
					CFG_FILTER_COEF:  coef_sh = cfg_data;
					default: ;
				endcase
			end
			// Results are checked before this edge's word is queued.
			if (result_valid && result_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$display("%0t ns: result word with nothing expected, got 0x%h",
						$time, result);
					fail_cnt++;
				end else begin
					want = due_results.pop_front();
					check_field("electrical_angle", want.electrical_angle,
						result.electrical_angle);
					check_field("span_position", want.span_position,
						result.span_position);
					check_field("filtered_speed", want.filtered_speed,
						result.filtered_speed);
				end
			end
			if (item_valid && item_ready) begin
				predicted = track_encoder(item);
				due_results.push_back(item_typed ? item_want : predicted);
			end
		end
	end

	// Result side: random stalls per word, with stretches of none.
	initial begin
		int stall;
		result_ready = 1'b0;
		take_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_burst = ~take_burst;
			stall = take_burst ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// Offer one word after a random gap and wait until it is taken.
	task automatic send_word(in_word_t w, logic typed, out_word_t want);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = ~send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		item_typed <= typed;
		item_want <= want;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		words_sent++;
	endtask

	// Stop offering and wait until every result has come back.
	task automatic settle();
		item_valid <= 1'b0;
		while (results_seen != words_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stimulus.
	initial begin
		logic [CW-1:0] ph_set [PHASES][3];
		in_word_t w;
		int rot_cnt;
		int rot_vel;
		int pick;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		item_typed = 1'b0;
		item_want = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ANGLE_FACTOR;
		cfg_data = '0;
		words_sent = 0;
		results_seen = 0;
		fail_cnt = 0;
		cycle_cnt = 0;
		send_burst = 1'b0;

		// Directed table: fresh state first, then span edges, register extremes.
		dir_tab = '{
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd0,     1'b0, 1'b1, '{16'd0, 16'd0, 16'sd0}},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd0,     1'b1, 1'b1, '{16'd0, 16'd0, 16'sd0}},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd1,     1'b0, 1'b1, '{16'd65, 16'd1, 16'sd0}},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd1000,  1'b0, 1'b1,
				'{16'd65000, 16'd1024, 16'sd0}},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd4000,  1'b0, 1'b1, '{16'd0, 16'd4096, 16'sd0}},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd16000, 1'b1, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd16100, 1'b1, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd63999, 1'b0, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd63999, 1'b1, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd64000, 1'b1, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd65535, 1'b1, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd0,     1'b1, 1'b0, '0},
			'{ROW_CFG,  CFG_ANGLE_FACTOR, 16'd65535, 1'b0, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd3999,  1'b0, 1'b0, '0},
			'{ROW_CFG,  CFG_ANGLE_FACTOR, 16'd0,     1'b0, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd3999,  1'b0, 1'b0, '0},
			'{ROW_CFG,  CFG_SPEED_RATE,   16'd0,     1'b0, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd32000, 1'b1, 1'b0, '0},
			'{ROW_CFG,  CFG_SPEED_RATE,   16'd65535, 1'b0, 1'b0, '0},
			'{ROW_CFG,  CFG_FILTER_COEF,  16'd65535, 1'b0, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd0,     1'b1, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd40000, 1'b1, 1'b0, '0},
			'{ROW_CFG,  CFG_FILTER_COEF,  16'd32768, 1'b0, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd8000,  1'b1, 1'b0, '0},
			'{ROW_WORD, CFG_ANGLE_FACTOR, 16'd8000,  1'b1, 1'b0, '0}
		};

		// Register settings for the random phases: defaults, extremes and random values.
		ph_set[0] = '{DEF_ANGLE_FACTOR, DEF_SPEED_RATE, DEF_FILTER_COEF};
		ph_set[1] = '{16'd0, 16'd0, 16'd0};
		ph_set[2] = '{16'd65535, 16'd65535, 16'd32768};
		ph_set[3] = '{16'd1, 16'd1, 16'd65535};
		ph_set[4] = '{CW'($urandom), CW'($urandom_range(1, 65535)),
			CW'($urandom_range(0, 32768))};
		ph_set[5] = '{16'd65535, 16'd65535, 16'd65535};
		ph_set[6] = '{16'd4, 16'd20000, 16'd16384};
		ph_set[7] = '{CW'($urandom), CW'($urandom), CW'($urandom)};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				settle();
				write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
			end else begin
				w.mode = dir_tab[i].mode;
				w.enc_ticks = dir_tab[i].value;
				send_word(w, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		// Random phases: mostly a rotating shaft, with jumps and counts past the span.
		rot_cnt = 0;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_reg(CFG_ANGLE_FACTOR, ph_set[p][0]);
			write_reg(CFG_SPEED_RATE, ph_set[p][1]);
			write_reg(CFG_FILTER_COEF, ph_set[p][2]);
			rot_vel = int'($urandom_range(0, 1200)) - 600;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(0, 9);
				case (pick)
					0: w.enc_ticks = CW'($urandom);
					1: w.enc_ticks = CW'($urandom_range(SPAN_COUNTS, 65535));
					2: begin
						rot_cnt = $urandom_range(0, SPAN_COUNTS - 1);
						w.enc_ticks = CW'(rot_cnt);
					end
					default: begin
						rot_cnt = rot_cnt + rot_vel + int'($urandom_range(0, 40)) - 20;
						if (rot_cnt < 0)
							rot_cnt = rot_cnt + SPAN_COUNTS;
						if (rot_cnt >= SPAN_COUNTS)
							rot_cnt = rot_cnt - SPAN_COUNTS;
						w.enc_ticks = CW'(rot_cnt);
					end
				endcase
				w.mode = ($urandom_range(0, 3) != 0);
				send_word(w, 1'b0, '0);
				// Now and then hold off until the block has fully drained.
				if ($urandom_range(0, 99) == 0)
					settle();
			end
		end

		// Drain and report.
		settle();
		repeat (12) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0t ns: %0d result words still expected, got none",
				$time, due_results.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("encoder_angle_speed_filter_tb OK");
		else
			$display("encoder_angle_speed_filter_tb NOT OK");
		$finish;
	end

endmodule

/* encoder_angle_speed_filter.f */
src/eas_pkg.sv
src/eas_dpath.sv
src/eas_ctrl.sv
src/encoder_angle_speed_filter.sv
sim/encoder_angle_speed_filter_tb.sv
